>>> hdl/base64_stream_encoder_top_defines.svh
// Assertion macros for the Base64 stream encoder.
// B64E_ASSERT checks a property that is masked while reset is held.
// B64E_ASSERT_RST checks a property that must also hold through reset.
`ifndef BASE64_STREAM_ENCODER_TOP_DEFINES_SVH
`define BASE64_STREAM_ENCODER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define B64E_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("b64e assertion failed");
`define B64E_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("b64e reset assertion failed");
`else
`define B64E_ASSERT(lbl, prop)
`define B64E_ASSERT_RST(lbl, prop)
`endif

`endif

>>> hdl/b64e_pkg.sv
package b64e_pkg;

  // ASCII '=' used for padding
  localparam logic [6:0] PAD_CHAR = 7'h3D;

  // number of pad characters closing a group
  localparam logic [1:0] PAD_NONE = 2'd0;
  localparam logic [1:0] PAD_ONE  = 2'd1;
  localparam logic [1:0] PAD_TWO  = 2'd2;

  // character slot of the fourth output of a group
  localparam logic [1:0] LAST_SLOT = 2'd3;

  // one group of up to three bytes handed from front to back
  typedef struct packed {
    logic [23:0] group;
    logic [1:0]  pad_cnt;
    logic        msg_end;
  } grp_t;

  // queue status seen by front and back
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // standard alphabet: A-Z, a-z, 0-9, '+', '/'
  function automatic logic [6:0] enc6(input logic [5:0] v);
    logic [6:0] v7;
    v7 = {1'b0, v};
    if (v < 6'd26) begin
      return v7 + 7'd65;
    end else if (v < 6'd52) begin
      return v7 + 7'd71;
    end else if (v < 6'd62) begin
      return v7 - 7'd4;
    end else if (v == 6'd62) begin
      return 7'd43;
    end else begin
      return 7'd47;
    end
  endfunction

endpackage

>>> hdl/base64_stream_encoder_top.sv
// A group's closing beat is queued, then loaded into the current-group register, and
//   its first character then goes to the output register. One character per cycle
//   with out_ready high; four characters per group, so output limits byte streams.
// Input is taken every cycle while the group queue has room (QUEUE_DEPTH groups).
// Reset (rst_n low, synchronous): pending bytes, queue count and out_valid cleared.
`include "base64_stream_encoder_top_defines.svh"

module base64_stream_encoder_top #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_data_byte,
  input  logic       in_end_of_message,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [6:0] out_symbol,
  output logic       out_run_last,
  output logic       out_message_last
);

  b64e_pkg::q_stat_t q_stat;
  b64e_pkg::grp_t    push_grp;
  b64e_pkg::grp_t    pop_grp;
  logic              push;
  logic              pop;

  // front: byte packing and group classification
  b64e_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_data_byte      (in_data_byte),
    .in_end_of_message (in_end_of_message),
    .q_stat            (q_stat),
    .push              (push),
    .push_grp          (push_grp)
  );

  // group queue between front and back
  b64e_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_grp (push_grp),
    .pop      (pop),
    .pop_grp  (pop_grp),
    .q_stat   (q_stat)
  );

  // back: character generation and output register
  b64e_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_valid          (!q_stat.empty),
    .q_grp            (pop_grp),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_symbol       (out_symbol),
    .out_run_last     (out_run_last),
    .out_message_last (out_message_last)
  );

  // checks
  `B64E_ASSERT(a_msg_last_ends_run, out_valid && out_message_last |-> out_run_last)
  `B64E_ASSERT(a_no_pop_empty, pop |-> !q_stat.empty)
  `B64E_ASSERT(a_q_full_not_empty, !(q_stat.full && q_stat.empty))
  `B64E_ASSERT_RST(a_reset_clears_out, !rst_n |=> !out_valid && q_stat.empty)

endmodule

>>> hdl/b64e_front.sv
module b64e_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_data_byte,
  input  logic              in_end_of_message,
  input  b64e_pkg::q_stat_t q_stat,
  output logic              push,
  output b64e_pkg::grp_t    push_grp
);

  logic [15:0] pend_r, pend_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic        acc;
  logic        emit;

  assign in_ready = !q_stat.full;
  assign acc      = in_valid && in_ready;

  // classify the beat: complete group, padded flush, or hold
  always_comb begin
    emit     = 1'b0;
    push_grp = '0;
    if (cnt_r[1]) begin
      emit             = 1'b1;
      push_grp.group   = {pend_r, in_data_byte};
      push_grp.pad_cnt = b64e_pkg::PAD_NONE;
      push_grp.msg_end = in_end_of_message;
    end else if (in_end_of_message) begin
      emit             = 1'b1;
      push_grp.msg_end = 1'b1;
      if (cnt_r == 2'd0) begin
        push_grp.group   = {in_data_byte, 16'h0000};
        push_grp.pad_cnt = b64e_pkg::PAD_TWO;
      end else begin
        push_grp.group   = {pend_r[15:8], in_data_byte, 8'h00};
        push_grp.pad_cnt = b64e_pkg::PAD_ONE;
      end
    end
  end

  assign push = acc && emit;

  // pending byte store
  always_comb begin
    pend_nxt = pend_r;
    cnt_nxt  = cnt_r;
    if (acc) begin
      if (emit) begin
        pend_nxt = '0;
        cnt_nxt  = '0;
      end else begin
        if (cnt_r == 2'd0) begin
          pend_nxt = {in_data_byte, 8'h00};
        end else begin
          pend_nxt = {pend_r[15:8], in_data_byte};
        end
        cnt_nxt = cnt_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
      cnt_r  <= '0;
    end else begin
      pend_r <= pend_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule

>>> hdl/b64e_queue.sv
module b64e_queue #(
  parameter int DEPTH = 2
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  b64e_pkg::grp_t    push_grp,
  input  logic              pop,
  output b64e_pkg::grp_t    pop_grp,
  output b64e_pkg::q_stat_t q_stat
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  b64e_pkg::grp_t mem_r [DEPTH];

  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign q_stat.full  = (cnt_r == CNT_W'(DEPTH));
  assign q_stat.empty = (cnt_r == '0);
  assign pop_grp      = mem_r[rd_ptr_r];

  // pointer wrap and fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_grp;
    end
  end

endmodule

>>> hdl/b64e_back.sv
module b64e_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_valid,
  input  b64e_pkg::grp_t q_grp,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [6:0]     out_symbol,
  output logic           out_run_last,
  output logic           out_message_last
);

  b64e_pkg::grp_t cur_r, cur_nxt;
  logic           busy_r, busy_nxt;
  logic [1:0]     idx_r, idx_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic [6:0]     sym_r;
  logic           rl_r;
  logic           ml_r;
  logic           adv;
  logic [6:0]     sym_c;
  logic           last_c;

  assign adv = !out_valid_r || out_ready;

  // character for the current slot
  always_comb begin
    case (idx_r)
      2'd0: sym_c = b64e_pkg::enc6(cur_r.group[23:18]);
      2'd1: sym_c = b64e_pkg::enc6(cur_r.group[17:12]);
      2'd2: sym_c = (cur_r.pad_cnt == b64e_pkg::PAD_TWO) ? b64e_pkg::PAD_CHAR
                                                         : b64e_pkg::enc6(cur_r.group[11:6]);
      default: sym_c = (cur_r.pad_cnt != b64e_pkg::PAD_NONE) ? b64e_pkg::PAD_CHAR
                                                             : b64e_pkg::enc6(cur_r.group[5:0]);
    endcase
  end

  assign last_c = (idx_r == b64e_pkg::LAST_SLOT);

  // group sequencer: load from queue when idle or on the last slot
  always_comb begin
    cur_nxt       = cur_r;
    busy_nxt      = busy_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r;
    pop           = 1'b0;
    if (!busy_r) begin
      pop      = q_valid;
      busy_nxt = q_valid;
      cur_nxt  = q_grp;
      idx_nxt  = '0;
    end
    if (adv) begin
      out_valid_nxt = busy_r;
      if (busy_r) begin
        if (last_c) begin
          pop      = q_valid;
          busy_nxt = q_valid;
          cur_nxt  = q_grp;
          idx_nxt  = '0;
        end else begin
          idx_nxt = idx_r + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    if (adv && busy_r) begin
      sym_r <= sym_c;
      rl_r  <= last_c;
      ml_r  <= last_c && cur_r.msg_end;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_symbol       = sym_r;
  assign out_run_last     = rl_r;
  assign out_message_last = ml_r;

endmodule

>>> tb/b64_char_checker.sv
module b64_char_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [7:0] in_data_byte,
  input  logic       in_end_of_message,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [6:0] out_symbol,
  input  logic       out_run_last,
  input  logic       out_message_last,
  output int         fail_count,
  output int         chars_due
);

  // standard alphabet, index 0 in the top byte
  localparam bit [511:0] B64_ALPHABET =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  typedef struct packed {
    logic [6:0] symbol;
    logic       run_last;
    logic       message_last;
  } b64_char_t;

  b64_char_t   char_queue[$];
  b64_char_t   want;
  b64_char_t   next_char;
  logic [15:0] held_bytes;
  logic [1:0]  held_cnt;
  logic [23:0] grp;
  int          pads;
  logic        emit;

  initial begin
    fail_count = 0;
    chars_due  = 0;
    held_bytes = '0;
    held_cnt   = '0;
  end

  function automatic logic [6:0] sextet_char(input logic [5:0] v);
    int idx;
    idx = 63 - int'(v);
    return B64_ALPHABET[idx*8 +: 7];
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      held_bytes = '0;
      held_cnt   = '0;
      char_queue.delete();
    end else begin
      // input beat: update held bytes, queue the characters it closes
      if (in_valid && in_ready) begin
        emit = 1'b1;
        pads = 0;
        if (held_cnt >= 2'd2) begin
          grp = {held_bytes, in_data_byte};
        end else if (!in_end_of_message) begin
          emit = 1'b0;
          if (held_cnt == 2'd0) begin
            held_bytes = {in_data_byte, 8'h00};
          end else begin
            held_bytes[7:0] = in_data_byte;
          end
          held_cnt = held_cnt + 2'd1;
        end else if (held_cnt == 2'd0) begin
          grp  = {in_data_byte, 16'h0000};
          pads = 2;
        end else begin
          grp  = {held_bytes[15:8], in_data_byte, 8'h00};
          pads = 1;
        end
        if (emit) begin
          for (int k = 0; k < 4; k++) begin
            next_char.symbol       = (k >= 4 - pads) ? b64e_pkg::PAD_CHAR
                                                     : sextet_char(grp[18 - 6*k +: 6]);
            next_char.run_last     = (k == 3);
            next_char.message_last = (k == 3) && in_end_of_message;
            char_queue.insert(char_queue.size(), next_char);
          end
          held_bytes = '0;
          held_cnt   = '0;
        end
      end

      // output beat: compare against the oldest queued character
      if (out_valid && out_ready) begin
        if (char_queue.size() == 0) begin
          $display("%0t: unexpected beat, expected none, got symbol %h rl %b ml %b",
                   $time, out_symbol, out_run_last, out_message_last);
          fail_count++;
        end else begin
          want = char_queue.pop_front();
          if (out_symbol !== want.symbol) begin
            $display("%0t: symbol expected %h got %h", $time, want.symbol, out_symbol);
            fail_count++;
          end
          if (out_run_last !== want.run_last) begin
            $display("%0t: run_last expected %b got %b", $time, want.run_last, out_run_last);
            fail_count++;
          end
          if (out_message_last !== want.message_last) begin
            $display("%0t: message_last expected %b got %b",
                     $time, want.message_last, out_message_last);
            fail_count++;
          end
        end
      end
    end
    chars_due = char_queue.size();
  end

endmodule

>>> tb/base64_stream_encoder_top_tb.sv
module base64_stream_encoder_top_tb;

  logic       clk;
  logic       rst_n             = 1'b0;
  logic       in_valid          = 1'b0;
  logic       in_ready;
  logic [7:0] in_data_byte      = 8'h00;
  logic       in_end_of_message = 1'b0;
  logic       out_valid;
  logic       out_ready         = 1'b0;
  logic [6:0] out_symbol;
  logic       out_run_last;
  logic       out_message_last;

  int fail_count;
  int chars_due;
  int idle_pct   = 11;
  int bytes_sent = 0;

  base64_stream_encoder_top DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data_byte     (in_data_byte),
    .in_end_of_message(in_end_of_message),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_symbol       (out_symbol),
    .out_run_last     (out_run_last),
    .out_message_last (out_message_last)
  );

  b64_char_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data_byte     (in_data_byte),
    .in_end_of_message(in_end_of_message),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_symbol       (out_symbol),
    .out_run_last     (out_run_last),
    .out_message_last (out_message_last),
    .fail_count       (fail_count),
    .chars_due        (chars_due)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop
  initial begin
    #1000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // receiver backpressure
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= idle_pct);
  end

  // one byte beat; called and returns at a falling edge
  task automatic send_byte(input logic [7:0] b, input logic eom);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid          <= 1'b1;
    in_data_byte      <= b;
    in_end_of_message <= eom;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    bytes_sent++;
  endtask

  task automatic send_random_message(input int len);
    for (int i = 0; i < len; i++) begin
      send_byte(8'($urandom_range(255)), i == len - 1);
    end
  endtask

  task automatic wait_for_drain();
    while (chars_due != 0) @(negedge clk);
  endtask

  initial begin
    int  len;
    bit  paused;
    paused = 1'b0;

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // single-byte messages: two pads
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    // two-byte messages: one pad
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b1);
    // full group closing the message
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b1);
    // full group mid-message, then padded tail
    send_byte(8'h4D, 1'b0);
    send_byte(8'h61, 1'b0);
    send_byte(8'h6E, 1'b0);
    send_byte(8'h4D, 1'b0);
    send_byte(8'h61, 1'b1);
    // '+' everywhere
    send_byte(8'hFB, 1'b0);
    send_byte(8'hEF, 1'b0);
    send_byte(8'hBE, 1'b1);
    // all zero group
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b1);

    // random messages, mostly short
    while (bytes_sent < 200) begin
      idle_pct = (bytes_sent >= 80 && bytes_sent < 150) ? 0 : 11;
      if (!paused && bytes_sent >= 170) begin
        // hold the sender until every character is out
        paused = 1'b1;
        in_valid <= 1'b0;
        @(negedge clk);
        wait_for_drain();
      end
      len = ($urandom_range(9) < 8) ? $urandom_range(1, 6) : $urandom_range(7, 20);
      send_random_message(len);
    end
    in_valid <= 1'b0;
    idle_pct = 11;

    wait_for_drain();
    repeat (20) @(negedge clk);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
